>>> rtl/core/cpsm_pkg.sv
// ----------------------------------------------------------------------------
// cpsm_pkg: shared types and constants of the coprime sum block
// Field widths, divider request and response records and sequencer states.
// ----------------------------------------------------------------------------
package cpsm_pkg;

  localparam int VALUE_BITS_DEF = 24;
  localparam int MAX_PRIMES_DEF = 8;
  localparam int FLD_W          = 24;
  localparam int MOD_W          = 31;
  localparam int FAC_SLOTS      = 10;
  localparam int FAC_IW         = 4;
  localparam int DIV_W          = 64;
  localparam int DSR_W          = 32;
  localparam int CNT_W          = 7;

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TCHK,
    S_TRES,
    S_TEND,
    S_TRI_A,
    S_TRI_B,
    S_TRI_M,
    S_TRI_R,
    S_TRI_D,
    S_W_SEL,
    S_W_CMP,
    S_W_Q,
    S_W_FMUL,
    S_W_FR,
    S_W_ACC,
    S_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic             long_op;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/core/cpsm_div.sv
// ----------------------------------------------------------------------------
// cpsm_div: shared restoring divider
// Produces quotient and remainder one bit per cycle, over VALUE_BITS or 64 bits.
// ----------------------------------------------------------------------------
module cpsm_div #(
  parameter int VALUE_BITS = cpsm_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cpsm_pkg::div_req_t req,
  output cpsm_pkg::div_rsp_t rsp
);

  logic                            run;
  logic                            done;
  logic [cpsm_pkg::CNT_W-1:0]      cnt;
  logic [cpsm_pkg::DIV_W-1:0]      dvd;
  logic [cpsm_pkg::DIV_W-1:0]      quo;
  logic [cpsm_pkg::DSR_W-1:0]      rem;
  logic [cpsm_pkg::DSR_W-1:0]      dsr;
  logic [cpsm_pkg::DSR_W:0]        trial;
  logic                            ge;

  always_comb begin
    trial = {rem, dvd[cpsm_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.long_op ? cpsm_pkg::CNT_W'(cpsm_pkg::DIV_W) : cpsm_pkg::CNT_W'(VALUE_BITS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == cpsm_pkg::CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.long_op ? req.dividend
                         : {req.dividend[VALUE_BITS-1:0], {(cpsm_pkg::DIV_W-VALUE_BITS){1'b0}}};
      dsr <= req.divisor;
      quo <= '0;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[cpsm_pkg::DIV_W-2:0], 1'b0};
      quo <= {quo[cpsm_pkg::DIV_W-2:0], ge};
      rem <= ge ? cpsm_pkg::DSR_W'(trial - {1'b0, dsr}) : trial[cpsm_pkg::DSR_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

>>> rtl/core/cpsm_seq.sv
// ----------------------------------------------------------------------------
// cpsm_seq: sequencer and datapath of the coprime sum
// Trial division, triangular numbers mod m and the inclusion-exclusion walk.
// ----------------------------------------------------------------------------
module cpsm_seq #(
  parameter int VALUE_BITS = cpsm_pkg::VALUE_BITS_DEF,
  parameter int MAX_PRIMES = cpsm_pkg::MAX_PRIMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cpsm_pkg::FLD_W-1:0]   n_in,
  input  logic [cpsm_pkg::FLD_W-1:0]   k_in,
  input  logic [cpsm_pkg::MOD_W-1:0]   m_in,
  output logic                         idle,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [cpsm_pkg::MOD_W-1:0]   res,
  output cpsm_pkg::div_req_t           req,
  input  cpsm_pkg::div_rsp_t           rsp
);

  localparam int VB    = VALUE_BITS;
  localparam int DEP_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int MW    = cpsm_pkg::MOD_W;
  localparam int IW    = cpsm_pkg::FAC_IW;

  cpsm_pkg::seq_state_t state, state_next, ret, ret_next;

  logic [VB-1:0]                 n_r;
  logic [VB-1:0]                 k_r;
  logic [MW-1:0]                 m_r;
  logic [VB-1:0]                 p_r;
  logic [VB+1:0]                 psq_r;
  logic                          found;
  logic [VB-1:0]                 fac [cpsm_pkg::FAC_SLOTS];
  logic [IW-1:0]                 fac_cnt;
  logic                          walk;
  logic [VB-1:0]                 t_r;
  logic [MW-1:0]                 ra;
  logic [MW-1:0]                 tri_r;
  logic [cpsm_pkg::DIV_W-1:0]    mul_r;
  logic [MW-1:0]                 acc;
  logic [DEP_W-1:0]              depth;
  logic [IW-1:0]                 idx [MAX_PRIMES];
  logic [VB-1:0]                 base [MAX_PRIMES];
  logic [VB-1:0]                 nd;

  logic [IW-1:0]                 cur_i;
  logic [VB-1:0]                 cur_fac;
  logic [VB:0]                   t_plus;
  logic [VB:0]                   a_v;
  logic [VB:0]                   b_v;
  logic [MW-1:0]                 term;
  logic [MW:0]                   acc_sum;
  logic [MW:0]                   acc_dif;
  logic [MW-1:0]                 acc_new;
  logic                          can_push;
  logic                          pop;
  logic                          mul_en;
  logic [31:0]                   mul_a;
  logic [31:0]                   mul_b;
  logic [DEP_W-1:0]              dep_up;
  logic [DEP_W-1:0]              dep_dn;

  always_comb begin
    cur_i    = idx[depth];
    cur_fac  = fac[cur_i];
    t_plus   = {1'b0, t_r} + 1'b1;
    if (!t_r[0]) begin
      a_v = {2'b00, t_r[VB-1:1]};
      b_v = t_plus;
    end else begin
      a_v = {1'b0, t_r};
      b_v = {1'b0, t_plus[VB:1]};
    end
    term     = rsp.rem[MW-1:0];
    acc_sum  = {1'b0, acc} + {1'b0, term};
    acc_dif  = {1'b0, acc} + {1'b0, m_r} - {1'b0, term};
    if (!depth[0]) begin
      acc_new = (acc_dif >= {1'b0, m_r}) ? MW'(acc_dif - {1'b0, m_r}) : acc_dif[MW-1:0];
    end else begin
      acc_new = (acc_sum >= {1'b0, m_r}) ? MW'(acc_sum - {1'b0, m_r}) : acc_sum[MW-1:0];
    end
    can_push = (int'(depth) + 1) < MAX_PRIMES;
    dep_up   = DEP_W'(depth + 1'b1);
    dep_dn   = DEP_W'(depth - 1'b1);
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    req          = '0;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    pop          = 1'b0;
    unique case (state)
      cpsm_pkg::S_IDLE: begin
        if (start) begin
          state_next = (m_in < MW'(2)) ? cpsm_pkg::S_DONE : cpsm_pkg::S_TCHK;
        end
      end
      cpsm_pkg::S_TCHK: begin
        if (psq_r > (VB+2)'(n_r)) begin
          state_next = cpsm_pkg::S_TEND;
        end else begin
          req.start    = 1'b1;
          req.dividend = cpsm_pkg::DIV_W'(n_r);
          req.divisor  = cpsm_pkg::DSR_W'(p_r);
          ret_next     = cpsm_pkg::S_TRES;
          state_next   = cpsm_pkg::S_WAIT;
        end
      end
      cpsm_pkg::S_TRES: begin
        if (rsp.rem == '0) begin
          req.start    = 1'b1;
          req.dividend = cpsm_pkg::DIV_W'(rsp.quo[VB-1:0]);
          req.divisor  = cpsm_pkg::DSR_W'(p_r);
          ret_next     = cpsm_pkg::S_TRES;
          state_next   = cpsm_pkg::S_WAIT;
        end else begin
          state_next = cpsm_pkg::S_TCHK;
        end
      end
      cpsm_pkg::S_TEND: state_next = cpsm_pkg::S_TRI_A;
      cpsm_pkg::S_TRI_A: begin
        req.start    = 1'b1;
        req.long_op  = 1'b1;
        req.dividend = cpsm_pkg::DIV_W'(a_v);
        req.divisor  = cpsm_pkg::DSR_W'(m_r);
        ret_next     = cpsm_pkg::S_TRI_B;
        state_next   = cpsm_pkg::S_WAIT;
      end
      cpsm_pkg::S_TRI_B: begin
        req.start    = 1'b1;
        req.long_op  = 1'b1;
        req.dividend = cpsm_pkg::DIV_W'(b_v);
        req.divisor  = cpsm_pkg::DSR_W'(m_r);
        ret_next     = cpsm_pkg::S_TRI_M;
        state_next   = cpsm_pkg::S_WAIT;
      end
      cpsm_pkg::S_TRI_M: begin
        mul_en     = 1'b1;
        mul_a      = 32'(ra);
        mul_b      = rsp.rem;
        state_next = cpsm_pkg::S_TRI_R;
      end
      cpsm_pkg::S_TRI_R, cpsm_pkg::S_W_FR: begin
        req.start    = 1'b1;
        req.long_op  = 1'b1;
        req.dividend = mul_r;
        req.divisor  = cpsm_pkg::DSR_W'(m_r);
        ret_next     = (state == cpsm_pkg::S_TRI_R) ? cpsm_pkg::S_TRI_D : cpsm_pkg::S_W_ACC;
        state_next   = cpsm_pkg::S_WAIT;
      end
      cpsm_pkg::S_TRI_D: begin
        if (!walk) begin
          state_next = cpsm_pkg::S_W_SEL;
        end else begin
          req.start    = 1'b1;
          req.long_op  = 1'b1;
          req.dividend = cpsm_pkg::DIV_W'(nd);
          req.divisor  = cpsm_pkg::DSR_W'(m_r);
          ret_next     = cpsm_pkg::S_W_FMUL;
          state_next   = cpsm_pkg::S_WAIT;
        end
      end
      cpsm_pkg::S_W_FMUL: begin
        mul_en     = 1'b1;
        mul_a      = rsp.rem;
        mul_b      = 32'(tri_r);
        state_next = cpsm_pkg::S_W_FR;
      end
      cpsm_pkg::S_W_ACC: state_next = cpsm_pkg::S_W_SEL;
      cpsm_pkg::S_W_SEL: begin
        if (cur_i >= fac_cnt) begin
          pop = 1'b1;
        end else begin
          mul_en     = 1'b1;
          mul_a      = 32'(base[depth]);
          mul_b      = 32'(cur_fac);
          state_next = cpsm_pkg::S_W_CMP;
        end
      end
      cpsm_pkg::S_W_CMP: begin
        if (mul_r > cpsm_pkg::DIV_W'(k_r)) begin
          pop = 1'b1;
        end else begin
          req.start    = 1'b1;
          req.dividend = cpsm_pkg::DIV_W'(k_r);
          req.divisor  = cpsm_pkg::DSR_W'(mul_r[VB-1:0]);
          ret_next     = cpsm_pkg::S_W_Q;
          state_next   = cpsm_pkg::S_WAIT;
        end
      end
      cpsm_pkg::S_W_Q: state_next = cpsm_pkg::S_TRI_A;
      cpsm_pkg::S_WAIT: begin
        if (rsp.done) begin
          state_next = ret;
        end
      end
      cpsm_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = cpsm_pkg::S_IDLE;
        end
      end
      default: state_next = cpsm_pkg::S_IDLE;
    endcase
    if (pop) begin
      state_next = (depth == '0) ? cpsm_pkg::S_DONE : cpsm_pkg::S_W_SEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpsm_pkg::S_IDLE;
      ret   <= cpsm_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_r <= mul_a * mul_b;
    end
    unique case (state)
      cpsm_pkg::S_IDLE: begin
        if (start) begin
          n_r     <= VB'(n_in);
          k_r     <= VB'(k_in);
          t_r     <= VB'(k_in);
          m_r     <= m_in;
          p_r     <= VB'(2);
          psq_r   <= (VB+2)'(4);
          found   <= 1'b0;
          fac_cnt <= '0;
          walk    <= 1'b0;
          acc     <= '0;
        end
      end
      cpsm_pkg::S_TRES: begin
        if (rsp.rem == '0) begin
          n_r <= rsp.quo[VB-1:0];
          if (!found) begin
            fac[fac_cnt] <= p_r;
            fac_cnt      <= fac_cnt + 1'b1;
            found        <= 1'b1;
          end
        end else begin
          found <= 1'b0;
          p_r   <= p_r + 1'b1;
          psq_r <= psq_r + {1'b0, p_r, 1'b1};
        end
      end
      cpsm_pkg::S_TEND: begin
        if (n_r > VB'(1)) begin
          fac[fac_cnt] <= n_r;
          fac_cnt      <= fac_cnt + 1'b1;
        end
      end
      cpsm_pkg::S_TRI_B: ra <= rsp.rem[MW-1:0];
      cpsm_pkg::S_TRI_D: begin
        tri_r <= rsp.rem[MW-1:0];
        if (!walk) begin
          acc     <= rsp.rem[MW-1:0];
          walk    <= 1'b1;
          depth   <= '0;
          idx[0]  <= '0;
          base[0] <= VB'(1);
        end
      end
      cpsm_pkg::S_W_CMP: nd <= mul_r[VB-1:0];
      cpsm_pkg::S_W_Q: t_r <= rsp.quo[VB-1:0];
      cpsm_pkg::S_W_ACC: begin
        acc <= acc_new;
        if (can_push) begin
          base[dep_up] <= nd;
          idx[dep_up]  <= cur_i + 1'b1;
          depth        <= dep_up;
        end else begin
          idx[depth] <= cur_i + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (pop && depth != '0) begin
      depth       <= dep_dn;
      idx[dep_dn] <= idx[dep_dn] + 1'b1;
    end
  end

  assign idle      = state == cpsm_pkg::S_IDLE;
  assign res_valid = state == cpsm_pkg::S_DONE;
  assign res       = acc;

endmodule

>>> rtl/core/coprime_sum_mod.sv
// ----------------------------------------------------------------------------
// coprime_sum_mod: sum of the integers 1..k coprime to n, modulo m
// Top level with the modulus register, input handshake and result register.
// ----------------------------------------------------------------------------
// The input channel takes n_value and limit_k on a transfer of in_valid and
// in_ready; the output channel presents sum_mod with out_valid until a transfer
// with out_ready. The modulus is written through cfg_wr_en and cfg_wr_data;
// the user writes it only while the block is idle, since the block itself
// does not enforce this. It resets to 1000000007.
// One item is worked at a time by a single bit-serial divider and a multiplier
// under a sequencer. Trial division tries candidate divisors up to sqrt(n).
// Then come the starting triangular number and one inclusion-exclusion term
// for each product of up to MAX_PRIMES distinct prime factors of n that does
// not exceed k. A modulus below two returns zero.
// The result register frees the core, so the next item is taken while a
// result waits; a stalled receiver holds the finished result of the second
// item in the core and in_ready stays low until it drains.
// Reset empties the result register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module coprime_sum_mod #(
  parameter int VALUE_BITS = cpsm_pkg::VALUE_BITS_DEF,
  parameter int MAX_PRIMES = cpsm_pkg::MAX_PRIMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cpsm_pkg::FLD_W-1:0] n_value,
  input  logic [cpsm_pkg::FLD_W-1:0] limit_k,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cpsm_pkg::MOD_W-1:0] sum_mod,
  input  logic                       cfg_wr_en,
  input  logic [cpsm_pkg::MOD_W-1:0] cfg_wr_data
);

  logic [cpsm_pkg::MOD_W-1:0] modulus;
  logic                       idle;
  logic                       res_valid;
  logic                       res_ready;
  logic [cpsm_pkg::MOD_W-1:0] res;
  cpsm_pkg::div_req_t         req;
  cpsm_pkg::div_rsp_t         rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= cpsm_pkg::MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  assign in_ready  = idle;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      sum_mod <= res;
    end
  end

  cpsm_seq #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_PRIMES(MAX_PRIMES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && idle),
    .n_in      (n_value),
    .k_in      (limit_k),
    .m_in      (modulus),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .req       (req),
    .rsp       (rsp)
  );

  cpsm_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

endmodule
